// File: hw/rtl/bpc_pkg.sv
// Shared types, widths and constants for the barometer compensation block.
// Holds the oversampling scale table and the register index codes.
// No dependencies; compile this file first.
package bpc_pkg;

	localparam int RAW_W  = 24;
	localparam int SC_W   = 24;
	localparam int TEMP_W = 20;
	localparam int PRES_W = 24;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 3;
	localparam int CODE_W = 3;

	// Register indexes on the configuration port.
	typedef enum logic [IDX_W-1:0] {
		REG_TEMP_PAIR   = 3'd0,
		REG_PRES_OFFSET = 3'd1,
		REG_PRES_LINEAR = 3'd2,
		REG_CROSS_FIRST = 3'd3,
		REG_HIGHER_ORD  = 3'd4,
		REG_PRES_CUBIC  = 3'd5,
		REG_PRES_OSR    = 3'd6,
		REG_TEMP_OSR    = 3'd7
	} reg_idx_t;

	// Calibration coefficients as signed fields.
	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
	} coef_t;

	// Each scale factor is m * 2^s with m = 2^j - 1. The divider works on
	// raw * 2^(23-s) divided by m, using a 32-bit reciprocal of m.
	typedef struct packed {
		logic [3:0]  shift;
		logic [7:0]  m;
		logic [31:0] recip;
	} scale_t;

	function automatic scale_t scale_info(input logic [CODE_W-1:0] code);
		scale_t s;
		case (code)
			3'd0:    s = '{shift: 4'd4,  m: 8'd1,   recip: 32'd4294967295};
			3'd1:    s = '{shift: 4'd4,  m: 8'd3,   recip: 32'd1431655765};
			3'd2:    s = '{shift: 4'd4,  m: 8'd7,   recip: 32'd613566756};
			3'd3:    s = '{shift: 4'd4,  m: 8'd15,  recip: 32'd286331153};
			3'd4:    s = '{shift: 4'd10, m: 8'd31,  recip: 32'd138547332};
			3'd5:    s = '{shift: 4'd10, m: 8'd63,  recip: 32'd68174084};
			3'd6:    s = '{shift: 4'd10, m: 8'd127, recip: 32'd33818640};
			default: s = '{shift: 4'd10, m: 8'd255, recip: 32'd16843009};
		endcase
		return s;
	endfunction

endpackage

// File: hw/rtl/bpc_scale.sv
// Three-stage scaler: raw reading divided by the oversampling scale factor.
// Gives a rounded, saturated Q1.23 value. Depends on bpc_pkg.
module bpc_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [bpc_pkg::RAW_W-1:0]   raw,
	input  logic [bpc_pkg::CODE_W-1:0]         code,
	output logic                               out_vld,
	output logic signed [bpc_pkg::SC_W-1:0]    scaled
);
	import bpc_pkg::*;

	scale_t      info;
	logic [23:0] raw_u;
	logic [23:0] mag;
	logic [33:0] xw;
	logic [33:0] lim_pos;
	logic [33:0] lim_neg;
	logic        clip;
	logic [31:0] x32;

	logic        vld_s1, vld_s2;
	logic [31:0] x_s1, x_s2;
	logic [31:0] recip_s1;
	logic [7:0]  m_s1, m_s2;
	logic        neg_s1, neg_s2;
	logic        clip_s1, clip_s2;
	logic [63:0] prod;
	logic [31:0] qe_s2;
	logic [31:0] rem;
	logic [31:0] quo;

	// Stage 1: magnitude, prescaled numerator with half-divisor, clip test.
	always_comb begin
		info    = scale_info(code);
		raw_u   = raw;
		mag     = raw_u[23] ? (~raw_u + 24'd1) : raw_u;
		xw      = (34'(mag) << info.shift) + 34'(info.m >> 1);
		lim_pos = 34'(info.m) << 23;
		lim_neg = lim_pos + 34'(info.m);
		clip    = raw_u[23] ? (xw >= lim_neg) : (xw >= lim_pos);
		x32     = (xw[33:32] != 2'd0) ? '1 : xw[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= x32;
		recip_s1 <= info.recip;
		m_s1     <= info.m;
		neg_s1   <= raw_u[23];
		clip_s1  <= clip;
	end

	// Stage 2: quotient estimate from the reciprocal, low by at most one.
	assign prod = 64'(x_s1) * 64'(recip_s1);

	always_ff @(posedge clk) begin
		qe_s2   <= prod[63:32];
		x_s2    <= x_s1;
		m_s2    <= m_s1;
		neg_s2  <= neg_s1;
		clip_s2 <= clip_s1;
	end

	// Stage 3: one correction step, then sign and saturation.
	always_comb begin
		rem = x_s2 - qe_s2 * 32'(m_s2);
		quo = qe_s2 + 32'(rem >= 32'(m_s2));
	end

	always_ff @(posedge clk) begin
		if (clip_s2) begin
			scaled <= neg_s2 ? {1'b1, {(SC_W-1){1'b0}}} : {1'b0, {(SC_W-1){1'b1}}};
		end else begin
			scaled <= neg_s2 ? -$signed(quo[SC_W-1:0]) : $signed(quo[SC_W-1:0]);
		end
	end

endmodule

// File: hw/rtl/bpc_poly.sv
// Seven-stage fixed-point evaluation of the temperature and pressure
// polynomials from the scaled readings. Depends on bpc_pkg.
module bpc_poly (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic signed [bpc_pkg::SC_W-1:0]    psc,
	input  logic signed [bpc_pkg::SC_W-1:0]    tsc,
	input  bpc_pkg::coef_t                     coef,
	output logic                               done,
	output logic signed [bpc_pkg::TEMP_W-1:0]  temperature_q8,
	output logic signed [bpc_pkg::PRES_W-1:0]  pressure_q4,
	output logic                               saturated
);
	import bpc_pkg::*;

	logic signed [11:0] c0, c1;
	logic signed [19:0] c00, c10;
	logic signed [15:0] c01, c11, c20, c21, c30;

	logic               v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic signed [39:0] m1_s4, m2_s4, m4_s4;
	logic signed [35:0] m3_s4;
	logic signed [23:0] p_s4, p_s5, p_s6, p_s7;
	logic signed [23:0] t_s4, t_s5, t_s6, t_s7;

	logic signed [41:0] a_w, d_w;
	logic signed [21:0] t_w;
	logic signed [33:0] a_s5, d_s5;
	logic signed [33:0] pc_s5, pc_s6, pc_s7, pc_s8;
	logic signed [TEMP_W-1:0] tq_s5, tq_s6, tq_s7, tq_s8, tq_s9;
	logic               ts_s5, ts_s6, ts_s7, ts_s8, ts_s9;

	logic signed [57:0] m5_s6, m6_s6;
	logic signed [58:0] b_w, e_w;
	logic signed [37:0] b_s7;
	logic signed [35:0] e_s7;
	logic signed [61:0] m7_s8;
	logic signed [59:0] m8_s8;
	logic signed [41:0] p16_w;
	logic signed [41:0] p16_s9;
	logic signed [42:0] pq_w;

	assign c0  = coef.c0;
	assign c1  = coef.c1;
	assign c00 = coef.c00;
	assign c10 = coef.c10;
	assign c01 = coef.c01;
	assign c11 = coef.c11;
	assign c20 = coef.c20;
	assign c21 = coef.c21;
	assign c30 = coef.c30;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= in_vld;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			done <= v_s9;
		end
	end

	// Stage 4: the four products that need only the scaled readings.
	always_ff @(posedge clk) begin
		m1_s4 <= c30 * psc;
		m2_s4 <= c21 * psc;
		m3_s4 <= c1 * tsc;
		m4_s4 <= c01 * tsc;
		p_s4  <= psc;
		t_s4  <= tsc;
	end

	// Stage 5: inner pressure terms, finished and clipped temperature.
	always_comb begin
		a_w = (42'(c20) <<< 16) + ((42'(m1_s4) + 42'sd64) >>> 7);
		d_w = (42'(c11) <<< 16) + ((42'(m2_s4) + 42'sd64) >>> 7);
		t_w = (22'(c0) <<< 7) + 22'((37'(m3_s4) + 37'sd16384) >>> 15);
	end

	always_ff @(posedge clk) begin
		a_s5  <= a_w[33:0];
		d_s5  <= d_w[33:0];
		pc_s5 <= 34'((41'(m4_s4) + 41'sd64) >>> 7);
		p_s5  <= p_s4;
		t_s5  <= t_s4;
		if (t_w > 22'sd524287) begin
			tq_s5 <= {1'b0, {(TEMP_W-1){1'b1}}};
			ts_s5 <= 1'b1;
		end else if (t_w < -22'sd524288) begin
			tq_s5 <= {1'b1, {(TEMP_W-1){1'b0}}};
			ts_s5 <= 1'b1;
		end else begin
			tq_s5 <= t_w[TEMP_W-1:0];
			ts_s5 <= 1'b0;
		end
	end

	// Stage 6: second products.
	always_ff @(posedge clk) begin
		m5_s6 <= a_s5 * p_s5;
		m6_s6 <= d_s5 * p_s5;
		p_s6  <= p_s5;
		t_s6  <= t_s5;
		pc_s6 <= pc_s5;
		tq_s6 <= tq_s5;
		ts_s6 <= ts_s5;
	end

	// Stage 7: round back to 16 fraction bits and add the linear term.
	always_comb begin
		b_w = (59'(c10) <<< 16) + ((59'(m5_s6) + 59'sd4194304) >>> 23);
		e_w = (59'(m6_s6) + 59'sd4194304) >>> 23;
	end

	always_ff @(posedge clk) begin
		b_s7  <= b_w[37:0];
		e_s7  <= e_w[35:0];
		p_s7  <= p_s6;
		t_s7  <= t_s6;
		pc_s7 <= pc_s6;
		tq_s7 <= tq_s6;
		ts_s7 <= ts_s6;
	end

	// Stage 8: outer products.
	always_ff @(posedge clk) begin
		m7_s8 <= b_s7 * p_s7;
		m8_s8 <= e_s7 * t_s7;
		pc_s8 <= pc_s7;
		tq_s8 <= tq_s7;
		ts_s8 <= ts_s7;
	end

	// Stage 9: sum of all pressure terms in Q.16.
	always_comb begin
		p16_w = (42'(c00) <<< 16)
			+ 42'((63'(m7_s8) + 63'sd4194304) >>> 23)
			+ 42'(pc_s8)
			+ 42'((61'(m8_s8) + 61'sd4194304) >>> 23);
	end

	always_ff @(posedge clk) begin
		p16_s9 <= p16_w;
		tq_s9  <= tq_s8;
		ts_s9  <= ts_s8;
	end

	// Stage 10: round to 1/16 Pa, clip and drive the result.
	assign pq_w = (43'(p16_s9) + 43'sd2048) >>> 12;

	always_ff @(posedge clk) begin
		temperature_q8 <= tq_s9;
		if (pq_w > 43'sd8388607) begin
			pressure_q4 <= {1'b0, {(PRES_W-1){1'b1}}};
			saturated   <= 1'b1;
		end else if (pq_w < -43'sd8388608) begin
			pressure_q4 <= {1'b1, {(PRES_W-1){1'b0}}};
			saturated   <= 1'b1;
		end else begin
			pressure_q4 <= pq_w[PRES_W-1:0];
			saturated   <= ts_s9;
		end
	end

endmodule

// File: hw/rtl/baro_pressure_temp_compensation.sv
// Top level of the barometer compensation block: configuration registers,
// two scalers and the polynomial pipeline. Depends on bpc_pkg, bpc_scale, bpc_poly.
//
// Usage:
// A transaction is accepted at a rising edge with start high and busy low.
// busy is always low: the pipeline takes a new raw pressure and temperature
// pair in every cycle, so the sustained rate is one pair per clock.
// Each transaction gives one result. done rises once the result has passed the
// scaler and polynomial registers and stays high for exactly one cycle, with
// temperature_q8, pressure_q4 and saturated valid in that cycle, when the receiver takes them.
// Results leave in the order of acceptance.
// The path runs through three scaler stages (reciprocal multiply and one
// correction) and seven polynomial stages, one multiply or round-and-add each.
// The receiver cannot stall; results are presented once and not held.
// Coefficients and oversampling codes are written through cfg_wr_en,
// cfg_index and cfg_wdata while no transaction is in flight; bits above a
// register's width are dropped. Reset clears the configuration registers and the
// valid bits to zero and empties the pipeline; no result is presented until a transaction enters.
module baro_pressure_temp_compensation (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [bpc_pkg::RAW_W-1:0]   raw_pressure,
	input  logic signed [bpc_pkg::RAW_W-1:0]   raw_temperature,
	input  logic                               cfg_wr_en,
	input  logic [bpc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]          cfg_wdata,
	output logic                               done,
	output logic signed [bpc_pkg::TEMP_W-1:0]  temperature_q8,
	output logic signed [bpc_pkg::PRES_W-1:0]  pressure_q4,
	output logic                               saturated
);
	import bpc_pkg::*;

	logic [23:0]       temp_pair_q;
	logic [19:0]       pres_offset_q;
	logic [19:0]       pres_linear_q;
	logic [31:0]       cross_first_q;
	logic [31:0]       higher_ord_q;
	logic [15:0]       pres_cubic_q;
	logic [CODE_W-1:0] pres_osr_q;
	logic [CODE_W-1:0] temp_osr_q;

	coef_t             coef;
	logic              accept;
	logic              p_vld, t_vld;
	logic signed [SC_W-1:0] psc, tsc;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_pair_q   <= '0;
			pres_offset_q <= '0;
			pres_linear_q <= '0;
			cross_first_q <= '0;
			higher_ord_q  <= '0;
			pres_cubic_q  <= '0;
			pres_osr_q    <= '0;
			temp_osr_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TEMP_PAIR:   temp_pair_q   <= cfg_wdata[23:0];
				REG_PRES_OFFSET: pres_offset_q <= cfg_wdata[19:0];
				REG_PRES_LINEAR: pres_linear_q <= cfg_wdata[19:0];
				REG_CROSS_FIRST: cross_first_q <= cfg_wdata[31:0];
				REG_HIGHER_ORD:  higher_ord_q  <= cfg_wdata[31:0];
				REG_PRES_CUBIC:  pres_cubic_q  <= cfg_wdata[15:0];
				REG_PRES_OSR:    pres_osr_q    <= cfg_wdata[CODE_W-1:0];
				REG_TEMP_OSR:    temp_osr_q    <= cfg_wdata[CODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the calibration subfields.
	always_comb begin
		coef.c0  = temp_pair_q[23:12];
		coef.c1  = temp_pair_q[11:0];
		coef.c00 = pres_offset_q;
		coef.c10 = pres_linear_q;
		coef.c01 = cross_first_q[31:16];
		coef.c11 = cross_first_q[15:0];
		coef.c20 = higher_ord_q[31:16];
		coef.c21 = higher_ord_q[15:0];
		coef.c30 = pres_cubic_q;
	end

	bpc_scale u_scale_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.raw     (raw_pressure),
		.code    (pres_osr_q),
		.out_vld (p_vld),
		.scaled  (psc)
	);

	bpc_scale u_scale_t (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.raw     (raw_temperature),
		.code    (temp_osr_q),
		.out_vld (t_vld),
		.scaled  (tsc)
	);

	bpc_poly u_poly (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_vld         (p_vld && t_vld),
		.psc            (psc),
		.tsc            (tsc),
		.coef           (coef),
		.done           (done),
		.temperature_q8 (temperature_q8),
		.pressure_q4    (pressure_q4),
		.saturated      (saturated)
	);

endmodule

// File: tb/tb_baro_pressure_temp_compensation.sv
// Self-checking testbench for the barometer pressure and temperature compensation block.
// Holds a scoreboard class with its own compensation predictor and the driving tasks.
// Depends on bpc_pkg and the baro_pressure_temp_compensation RTL.
`timescale 1ns / 100ps

module tb_baro_pressure_temp_compensation;
	import bpc_pkg::*;

	localparam int LATENCY = 10;

	// One compensated reading as the block presents it.
	typedef struct {
		logic signed [TEMP_W-1:0] temp_q8;
		logic signed [PRES_W-1:0] pres_q4;
		logic                     sat;
	} reading_t;

	// Predicts compensated readings and checks them in order of acceptance.
	class comp_scoreboard;
		logic [31:0] regs [8];
		reading_t    pending [$];
		int          errors;
		int          checked;

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_TEMP_PAIR:   regs[idx] = val & 32'hFFFFFF;
				REG_PRES_OFFSET: regs[idx] = val & 32'hFFFFF;
				REG_PRES_LINEAR: regs[idx] = val & 32'hFFFFF;
				REG_PRES_CUBIC:  regs[idx] = val & 32'hFFFF;
				REG_PRES_OSR:    regs[idx] = val & 32'h7;
				REG_TEMP_OSR:    regs[idx] = val & 32'h7;
				default:         regs[idx] = val;
			endcase
		endfunction

		// Rounds half up after dropping n fraction bits.
		function longint round_shift(longint v, int n);
			return (v + (longint'(1) << (n - 1))) >>> n;
		endfunction

		// Divides by the oversampling scale factor into Q1.23, ties away from zero.
		function longint scale_q23(logic signed [RAW_W-1:0] raw, logic [2:0] code);
			longint k, mag, q;
			case (code)
				3'd0: k = 524288;
				3'd1: k = 1572864;
				3'd2: k = 3670016;
				3'd3: k = 7864320;
				3'd4: k = 253952;
				3'd5: k = 516096;
				3'd6: k = 1040384;
				default: k = 2088960;
			endcase
			mag = raw < 0 ? -longint'(raw) : longint'(raw);
			q = (mag * 64'sd8388608 + k / 2) / k;
			if (raw < 0)
				q = -q;
			if (q > 8388607)
				q = 8388607;
			if (q < -8388608)
				q = -8388608;
			return q;
		endfunction

		function void note_input(logic signed [RAW_W-1:0] rp, logic signed [RAW_W-1:0] rt);
			longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
			longint p, t, tq, a, b, d, p16, pq;
			reading_t r;
			c0  = longint'($signed(regs[REG_TEMP_PAIR][23:12]));
			c1  = longint'($signed(regs[REG_TEMP_PAIR][11:0]));
			c00 = longint'($signed(regs[REG_PRES_OFFSET][19:0]));
			c10 = longint'($signed(regs[REG_PRES_LINEAR][19:0]));
			c01 = longint'($signed(regs[REG_CROSS_FIRST][31:16]));
			c11 = longint'($signed(regs[REG_CROSS_FIRST][15:0]));
			c20 = longint'($signed(regs[REG_HIGHER_ORD][31:16]));
			c21 = longint'($signed(regs[REG_HIGHER_ORD][15:0]));
			c30 = longint'($signed(regs[REG_PRES_CUBIC][15:0]));
			p = scale_q23(rp, regs[REG_PRES_OSR][2:0]);
			t = scale_q23(rt, regs[REG_TEMP_OSR][2:0]);
			r.sat = 1'b0;
			tq = c0 * 128 + round_shift(c1 * t, 15);
			if (tq > 524287) begin
				tq = 524287;
				r.sat = 1'b1;
			end else if (tq < -524288) begin
				tq = -524288;
				r.sat = 1'b1;
			end
			a = c20 * 65536 + round_shift(c30 * p, 7);
			b = c10 * 65536 + round_shift(a * p, 23);
			d = c11 * 65536 + round_shift(c21 * p, 7);
			p16 = c00 * 65536 + round_shift(b * p, 23) + round_shift(c01 * t, 7)
				+ round_shift(round_shift(d * p, 23) * t, 23);
			pq = round_shift(p16, 12);
			if (pq > 8388607) begin
				pq = 8388607;
				r.sat = 1'b1;
			end else if (pq < -8388608) begin
				pq = -8388608;
				r.sat = 1'b1;
			end
			r.temp_q8 = tq[TEMP_W-1:0];
			r.pres_q4 = pq[PRES_W-1:0];
			pending.push_back(r);
		endfunction

		function void check_result(reading_t got);
			reading_t want;
			if (pending.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.temp_q8 !== want.temp_q8) begin
				$error("temperature_q8 expected %0d actual %0d", want.temp_q8, got.temp_q8);
				errors++;
			end
			if (got.pres_q4 !== want.pres_q4) begin
				$error("pressure_q4 expected %0d actual %0d", want.pres_q4, got.pres_q4);
				errors++;
			end
			if (got.sat !== want.sat) begin
				$error("saturated expected %0b actual %0b", want.sat, got.sat);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [RAW_W-1:0] raw_pressure;
	logic signed [RAW_W-1:0] raw_temperature;
	logic cfg_wr_en;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic done;
	logic signed [TEMP_W-1:0] temperature_q8;
	logic signed [PRES_W-1:0] pressure_q4;
	logic saturated;

	comp_scoreboard sb;
	int idle_pct;
	int sent;

	baro_pressure_temp_compensation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.raw_pressure(raw_pressure), .raw_temperature(raw_temperature),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done), .temperature_q8(temperature_q8), .pressure_q4(pressure_q4),
		.saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Timeout guard for a hung pipeline.
	initial begin
		#2000000;
		$display("baro_pressure_temp_compensation regression: fail");
		$finish;
	end

	// Result monitor: every strobe is checked against the oldest prediction.
	always @(posedge clk) begin
		reading_t r;
		if (arst_n && done === 1'b1) begin
			r.temp_q8 = temperature_q8;
			r.pres_q4 = pressure_q4;
			r.sat = saturated;
			sb.check_result(r);
		end
	end

	// Writes one register while the pipeline is empty.
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_wr_en <= 1'b0;
	endtask

	// Presents one transaction, with a random gap before it in idle phases.
	task automatic send_pair(logic signed [RAW_W-1:0] rp, logic signed [RAW_W-1:0] rt);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		raw_pressure <= rp;
		raw_temperature <= rt;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_input(rp, rt);
		sent++;
	endtask

	// Lets every outstanding result drain out.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Random raw value: mostly full range, sometimes an extreme or a small value near zero.
	function automatic logic signed [RAW_W-1:0] rand_raw();
		case ($urandom_range(9))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(4095))) - 24'sd2048;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic load_coefs(bit extreme);
		if (extreme) begin
			write_reg(REG_TEMP_PAIR, $urandom_range(1) ? 32'h7FF7FF : 32'h800800);
			write_reg(REG_PRES_OFFSET, $urandom_range(1) ? 32'h7FFFF : 32'h80000);
			write_reg(REG_PRES_LINEAR, $urandom_range(1) ? 32'h7FFFF : 32'h80000);
			write_reg(REG_CROSS_FIRST, $urandom_range(1) ? 32'h7FFF7FFF : 32'h80008000);
			write_reg(REG_HIGHER_ORD, $urandom_range(1) ? 32'h7FFF7FFF : 32'h80008000);
			write_reg(REG_PRES_CUBIC, $urandom_range(1) ? 32'h7FFF : 32'h8000);
		end else begin
			write_reg(REG_TEMP_PAIR, $urandom);
			write_reg(REG_PRES_OFFSET, $urandom);
			write_reg(REG_PRES_LINEAR, $urandom);
			write_reg(REG_CROSS_FIRST, $urandom);
			write_reg(REG_HIGHER_ORD, $urandom);
			write_reg(REG_PRES_CUBIC, $urandom);
		end
		write_reg(REG_PRES_OSR, $urandom);
		write_reg(REG_TEMP_OSR, $urandom);
	endtask

	initial begin
		int phase_pct [4];
		phase_pct = '{0, 84, 0, 25};
		sb = new();
		sb.errors = 0;
		sb.checked = 0;
		foreach (sb.regs[i])
			sb.regs[i] = '0;
		sent = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		raw_pressure = '0;
		raw_temperature = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero coefficients, then extremes under every scale code, then small readings.
		send_pair(24'sh7FFFFF, 24'sh800000);
		drain();
		load_coefs(1'b1);
		for (int code = 0; code < 8; code++) begin
			write_reg(REG_PRES_OSR, code);
			write_reg(REG_TEMP_OSR, 7 - code);
			send_pair(24'sh7FFFFF, 24'sh7FFFFF);
			send_pair(24'sh800000, 24'sh800000);
			drain();
		end
		send_pair(24'sd0, 24'sd0);
		send_pair(24'sd1, -24'sd1);
		drain();

		// Random: each block of 100 runs under new coefficients and idle phase.
		for (int blk = 0; blk < 20; blk++) begin
			idle_pct = phase_pct[blk % 4];
			load_coefs(blk % 5 == 4);
			for (int i = 0; i < 100; i++) begin
				send_pair(rand_raw(), rand_raw());
				// Hold off once mid-block until the pipeline empties.
				if (blk == 1 && i == 50) begin
					start <= 1'b0;
					while (sb.pending.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("Sent %0d pressure/temperature pairs over 22 coefficient sets and checked %0d",
			sent, sb.checked);
		$display("readings, with extremes, every oversampling code and four idle phases.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("baro_pressure_temp_compensation regression: pass");
		else
			$display("baro_pressure_temp_compensation regression: fail");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_scale.sv
hw/rtl/bpc_poly.sv
hw/rtl/baro_pressure_temp_compensation.sv
tb/tb_baro_pressure_temp_compensation.sv
